// File: src/asch_pkg.sv
// Shared constants and types for the allocation size-class histogram.
package asch_pkg;

	// Request codes carried in the cmd field.
	typedef enum logic {
		CMD_RECORD = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	// Fixed field widths of the request and result channels.
	localparam int SIZE_W        = 32;
	localparam int BIN_FIELD_W   = 6;
	localparam int COUNT_FIELD_W = 32;
	localparam int BYTE_BITS     = 48;

	// Size-class rule: sub-class bits per octave, class offset, small-size limit.
	localparam int SUB_BITS     = 2;
	localparam int CLASS_OFFSET = 19;
	localparam int SMALL_MAX    = 16;

	// Width used for class arithmetic before clamping.
	localparam int CLASS_W = 8;

	// Controls handed from the pipeline to the bin store.
	typedef struct packed {
		logic en;
		logic wr_en;
	} store_ctl_t;

endpackage

// File: src/asch_classify.sv
// Maps a request to the bin it touches: size class for records, clamped index for reads.
module asch_classify #(
	parameter int NUM_BINS = 60,
	parameter int BIN_W    = 6
) (
	input  asch_pkg::cmd_t                     cmd,
	input  logic [asch_pkg::SIZE_W-1:0]        size,
	input  logic [asch_pkg::BIN_FIELD_W-1:0]   read_bin,
	output logic [BIN_W-1:0]                   bin_idx
);
	import asch_pkg::*;

	localparam int E_W = $clog2(SIZE_W);
	localparam logic [CLASS_W-1:0] LAST_BIN = CLASS_W'(NUM_BINS - 1);

	logic [CLASS_W-1:0] cls;
	logic [CLASS_W-1:0] rd_cls;

	// Leading-one search on size-1 gives the octave and the two bits below it.
	always_comb begin
		logic [SIZE_W-1:0]   m;
		logic [E_W-1:0]      e;
		logic [SUB_BITS-1:0] sub;
		logic [CLASS_W-1:0]  raw;
		m   = size - SIZE_W'(1);
		e   = '0;
		sub = '0;
		for (int i = SUB_BITS; i < SIZE_W; i++) begin
			if (m[i]) begin
				e   = E_W'(i);
				sub = m[i-1 -: SUB_BITS];
			end
		end
		raw = (CLASS_W'(e) << SUB_BITS) + CLASS_W'({1'b1, sub}) - CLASS_W'(CLASS_OFFSET);
		if (size <= SIZE_W'(SMALL_MAX)) begin
			cls = '0;
		end else if (raw > LAST_BIN) begin
			cls = LAST_BIN;
		end else begin
			cls = raw;
		end
	end

	// Reads past the last bin fall onto the last bin.
	always_comb begin
		if (CLASS_W'(read_bin) > LAST_BIN) begin
			rd_cls = LAST_BIN;
		end else begin
			rd_cls = CLASS_W'(read_bin);
		end
	end

	assign bin_idx = (cmd == CMD_RECORD) ? cls[BIN_W-1:0] : rd_cls[BIN_W-1:0];

endmodule

// File: src/asch_update.sv
// Saturating count and byte-total update for one bin, and selection of the result.
module asch_update #(
	parameter int COUNT_BITS = 32
) (
	input  asch_pkg::cmd_t                    cmd,
	input  logic [asch_pkg::SIZE_W-1:0]       size,
	input  logic [COUNT_BITS-1:0]             cur_count,
	input  logic [asch_pkg::BYTE_BITS-1:0]    cur_bytes,
	output logic [COUNT_BITS-1:0]             new_count,
	output logic [asch_pkg::BYTE_BITS-1:0]    new_bytes,
	output logic [COUNT_BITS-1:0]             res_count,
	output logic [asch_pkg::BYTE_BITS-1:0]    res_bytes
);
	import asch_pkg::*;

	logic [BYTE_BITS:0] sum;

	// The count holds at its maximum; the byte total clamps on carry out.
	assign new_count = (&cur_count) ? cur_count : cur_count + COUNT_BITS'(1);
	assign sum       = {1'b0, cur_bytes} + (BYTE_BITS + 1)'(size);
	assign new_bytes = sum[BYTE_BITS] ? {BYTE_BITS{1'b1}} : sum[BYTE_BITS-1:0];

	// A record reports the updated bin, a read reports it as stored.
	assign res_count = (cmd == CMD_RECORD) ? new_count : cur_count;
	assign res_bytes = (cmd == CMD_RECORD) ? new_bytes : cur_bytes;

endmodule

// File: src/asch_bin_store.sv
// Per-bin count and byte-total memory with valid bits, registered read and write bypass.
module asch_bin_store #(
	parameter int NUM_BINS   = 60,
	parameter int COUNT_BITS = 32,
	parameter int BIN_W      = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  asch_pkg::store_ctl_t              ctl,
	input  logic [BIN_W-1:0]                  rd_addr,
	input  logic [BIN_W-1:0]                  wr_addr,
	input  logic [COUNT_BITS-1:0]             wr_count,
	input  logic [asch_pkg::BYTE_BITS-1:0]    wr_bytes,
	output logic [COUNT_BITS-1:0]             rd_count,
	output logic [asch_pkg::BYTE_BITS-1:0]    rd_bytes
);
	import asch_pkg::*;

	localparam int ENTRY_W = COUNT_BITS + BYTE_BITS;

	logic [ENTRY_W-1:0]  mem [NUM_BINS];
	logic [NUM_BINS-1:0] vld_q;
	logic [ENTRY_W-1:0]  mem_rd_q;
	logic [ENTRY_W-1:0]  byp_q;
	logic                hit_q;
	logic                rd_vld_q;
	logic [ENTRY_W-1:0]  rd_data;

	// Memory write port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= {wr_count, wr_bytes};
		end
	end

	// Registered read, plus a copy of the data written in the same cycle.
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			mem_rd_q <= mem[rd_addr];
			byp_q    <= {wr_count, wr_bytes};
		end
	end

	// Valid bits stand in for clearing the memory at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			hit_q    <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.en) begin
				hit_q    <= ctl.wr_en && (wr_addr == rd_addr);
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// A same-cycle write wins; a bin never written reads as zero.
	assign rd_data  = hit_q ? byp_q : (rd_vld_q ? mem_rd_q : '0);
	assign rd_count = rd_data[ENTRY_W-1 -: COUNT_BITS];
	assign rd_bytes = rd_data[BYTE_BITS-1:0];

endmodule

// File: src/alloc_size_class_histogram_top.sv
// Top level of the allocation size-class histogram.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------
//  request  | in_valid / in_stall | cmd, alloc_size, read_bin
//  result   | out_valid/out_stall | bin, event_count, byte_total
//
// One request per cycle is accepted into the input register while in_stall is low; its result
// passes through the bin store read register, then the result register.
// The bin store's read-modify-write of one bin per cycle, with bypass of the write made in
// the same cycle, sets that rate.
// Reset clears the valid bits of the store at once, so every bin reads zero; no clearing pass.
// A stalled result freezes the whole pipeline and raises in_stall in the same cycle.
module alloc_size_class_histogram_top #(
	parameter int NUM_BINS   = 60,
	parameter int SIZE_BITS  = 32,
	parameter int COUNT_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  cmd,
	input  logic [asch_pkg::SIZE_W-1:0]           alloc_size,
	input  logic [asch_pkg::BIN_FIELD_W-1:0]      read_bin,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [asch_pkg::BIN_FIELD_W-1:0]      bin,
	output logic [asch_pkg::COUNT_FIELD_W-1:0]    event_count,
	output logic [asch_pkg::BYTE_BITS-1:0]        byte_total
);
	import asch_pkg::*;

	localparam int BIN_W = $clog2(NUM_BINS);
	localparam logic [63:0] SIZE_MASK64 = (64'd1 << SIZE_BITS) - 64'd1;
	localparam logic [SIZE_W-1:0] SIZE_MASK = SIZE_MASK64[SIZE_W-1:0];

	logic                  adv;
	store_ctl_t            store_ctl;

	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic [SIZE_W-1:0]     size_s1;
	logic [BIN_FIELD_W-1:0] rbin_s1;
	logic [BIN_W-1:0]      bin_s1;

	logic                  valid_s2;
	cmd_t                  cmd_s2;
	logic [SIZE_W-1:0]     size_s2;
	logic [BIN_W-1:0]      bin_s2;

	logic [COUNT_BITS-1:0] cur_count;
	logic [BYTE_BITS-1:0]  cur_bytes;
	logic [COUNT_BITS-1:0] new_count;
	logic [BYTE_BITS-1:0]  new_bytes;
	logic [COUNT_BITS-1:0] res_count;
	logic [BYTE_BITS-1:0]  res_bytes;

	logic                  out_valid_q;
	logic [BIN_FIELD_W-1:0] bin_q;
	logic [COUNT_FIELD_W-1:0] count_q;
	logic [BYTE_BITS-1:0]  bytes_q;

	logic [CLASS_W-1:0]    bin_wide;
	logic [63:0]           count_wide;

	// The pipeline moves unless a result is waiting and stalled.
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	assign store_ctl.en    = adv;
	assign store_ctl.wr_en = adv && valid_s2 && (cmd_s2 == CMD_RECORD);

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Request payload through the first two stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= cmd_t'(cmd);
			size_s1 <= alloc_size & SIZE_MASK;
			rbin_s1 <= read_bin;
			cmd_s2  <= cmd_s1;
			size_s2 <= size_s1;
			bin_s2  <= bin_s1;
		end
	end

	// Bin selection in the first stage drives the store read address.
	asch_classify #(
		.NUM_BINS (NUM_BINS),
		.BIN_W    (BIN_W)
	) u_classify (
		.cmd      (cmd_s1),
		.size     (size_s1),
		.read_bin (rbin_s1),
		.bin_idx  (bin_s1)
	);

	asch_bin_store #(
		.NUM_BINS   (NUM_BINS),
		.COUNT_BITS (COUNT_BITS),
		.BIN_W      (BIN_W)
	) u_bin_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (store_ctl),
		.rd_addr  (bin_s1),
		.wr_addr  (bin_s2),
		.wr_count (new_count),
		.wr_bytes (new_bytes),
		.rd_count (cur_count),
		.rd_bytes (cur_bytes)
	);

	// Second stage: update the bin and choose what to report.
	asch_update #(
		.COUNT_BITS (COUNT_BITS)
	) u_update (
		.cmd       (cmd_s2),
		.size      (size_s2),
		.cur_count (cur_count),
		.cur_bytes (cur_bytes),
		.new_count (new_count),
		.new_bytes (new_bytes),
		.res_count (res_count),
		.res_bytes (res_bytes)
	);

	assign bin_wide   = CLASS_W'(bin_s2);
	assign count_wide = 64'(res_count);

	// Result register.
	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			bin_q   <= bin_wide[BIN_FIELD_W-1:0];
			count_q <= count_wide[COUNT_FIELD_W-1:0];
			bytes_q <= res_bytes;
		end
	end

	assign out_valid   = out_valid_q;
	assign bin         = bin_q;
	assign event_count = count_q;
	assign byte_total  = bytes_q;

`ifndef SYNTH
	// A request leaving the second stage shows up as a result.
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s2 |=> out_valid)
		else $error("request in second stage produced no result");

	// A recorded allocation never reports an empty bin.
	a_record_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(COUNT_BITS <= COUNT_FIELD_W) && adv && valid_s2 && (cmd_s2 == CMD_RECORD)
		|=> event_count != '0)
		else $error("record reported a zero event count");

	// No store write while a result is held by a stall.
	a_no_write_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !store_ctl.wr_en)
		else $error("bin store written during output stall");

	// The bin in flight always lies inside the store.
	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (CLASS_W'(bin_s2) <= CLASS_W'(NUM_BINS - 1)))
		else $error("bin index beyond last bin");

	// A stall holds the pipeline contents for the next cycle.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(bin_s2) && $stable(valid_s2))
		else $error("second stage moved during output stall");
`endif

endmodule
